[sv/gated_position_error_average_unit_macros.svh]
// Assertion macros shared by the checker of the gated position error average unit.
`ifndef GATED_POSITION_ERROR_AVERAGE_UNIT_MACROS_SVH
`define GATED_POSITION_ERROR_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GPEA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPEA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define GPEA_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gpea_pkg.sv]
// Shared types and constants of the gated position error average unit.
package gpea_pkg;

    // Field widths.
    localparam int ROLL_W  = 17;
    localparam int POS_W   = 31;
    localparam int DIFF_W  = 32;
    localparam int LIMIT_W = 16;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index, as carried in paddr[2].
    localparam logic REG_ROLL_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] ROLL_LIMIT_RESET = 16'd1280;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic                     take;
        logic signed [DIFF_W-1:0] lat_diff;
        logic signed [DIFF_W-1:0] lon_diff;
    } item_t;

endpackage

[sv/gpea_front.sv]
// Front end: accepts samples, gates them on roll and forms the position differences.
module gpea_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gpea_pkg::ROLL_W-1:0]  roll_angle,
    input  logic signed [gpea_pkg::POS_W-1:0]   ins_latitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   ins_longitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   gps_latitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   gps_longitude,
    input  logic [gpea_pkg::LIMIT_W-1:0]        roll_limit,
    input  logic                                q_full,
    output logic                                push,
    output gpea_pkg::item_t                     push_item
);

    logic                                 stage_valid_reg;
    logic                                 stage_valid_next;
    gpea_pkg::item_t                      stage_reg;
    gpea_pkg::item_t                      stage_next;
    logic                                 accept;
    logic [gpea_pkg::ROLL_W-1:0]          roll_bits;
    logic [gpea_pkg::ROLL_W-1:0]          roll_mag;

    // The stage holds one classified transaction until the queue takes it.
    assign in_stall  = stage_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = stage_valid_reg && !q_full;
    assign push_item = stage_reg;

    // Roll magnitude; the most negative roll maps to 2^16, above any limit.
    assign roll_bits = roll_angle;
    assign roll_mag  = roll_bits[gpea_pkg::ROLL_W-1] ? (~roll_bits + gpea_pkg::ROLL_W'(1))
                                                     : roll_bits;

    // Classification and differences, inertial minus GPS.
    always_comb
    begin
        stage_next.take     = roll_mag <= gpea_pkg::ROLL_W'(roll_limit);
        stage_next.lat_diff = {ins_latitude[gpea_pkg::POS_W-1], ins_latitude}
                            - {gps_latitude[gpea_pkg::POS_W-1], gps_latitude};
        stage_next.lon_diff = {ins_longitude[gpea_pkg::POS_W-1], ins_longitude}
                            - {gps_longitude[gpea_pkg::POS_W-1], gps_longitude};
    end

    // Stage occupancy.
    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

[sv/gpea_fifo.sv]
// Two-entry queue that decouples the front end from the averaging back end.
module gpea_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gpea_pkg::item_t push_item,
    input  logic            pop,
    output logic            q_valid,
    output logic            q_full,
    output gpea_pkg::item_t q_item
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gpea_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == CNT_W'(DEPTH);
    assign q_item  = entry_reg[rd_ptr_reg];

    // Fill level.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/gpea_div.sv]
// Bit-serial signed divider: a running sum over the sample count, truncated toward zero.
module gpea_div #(
    parameter int SUM_W = 38,
    parameter int CNT_W = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [SUM_W-1:0]            dividend,
    input  logic [CNT_W-1:0]                   divisor,
    output logic                               done,
    output logic signed [gpea_pkg::DIFF_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic               neg_reg;
    logic [SUM_W-1:0]   work_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   dvd_bits;
    logic [SUM_W-1:0]   dvd_mag;
    logic [CNT_W:0]     rem_shift;
    logic [CNT_W:0]     rem_diff;
    logic               fits;
    logic [SUM_W-1:0]   q_signed;

    // Magnitude of the dividend; the sign is applied again at the end.
    assign dvd_bits = dividend;
    assign dvd_mag  = dvd_bits[SUM_W-1] ? (~dvd_bits + SUM_W'(1)) : dvd_bits;

    // One restoring step: bring in the next dividend bit and try the subtract.
    assign rem_shift = {rem_reg, work_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    assign q_signed = neg_reg ? (~work_reg + SUM_W'(1)) : work_reg;
    assign quotient = q_signed[gpea_pkg::DIFF_W-1:0];
    assign done     = done_reg;

    // Step sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dvd_mag;
            rem_reg  <= '0;
            neg_reg  <= dvd_bits[SUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            work_reg <= {work_reg[SUM_W-2:0], fits};
        end
    end

endmodule

[sv/gpea_back.sv]
// Back end: window ring, running sums, mean division and the result register.
module gpea_back #(
    parameter int WINDOW = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  gpea_pkg::item_t                    q_item,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [gpea_pkg::DIFF_W-1:0] mean_latitude_error,
    output logic signed [gpea_pkg::DIFF_W-1:0] mean_longitude_error,
    output logic                               sample_taken
);

    localparam int DIFF_W = gpea_pkg::DIFF_W;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = DIFF_W + $clog2(WINDOW);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_LAUNCH = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_RESULT = 5'b10000
    } back_state_t;

    back_state_t               state_reg;
    back_state_t               state_next;
    gpea_pkg::item_t           item_reg;
    logic [IDX_W-1:0]          slot_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [SUM_W-1:0]   lat_sum_reg;
    logic signed [SUM_W-1:0]   lon_sum_reg;
    logic signed [DIFF_W-1:0]  lat_hold_reg;
    logic signed [DIFF_W-1:0]  lon_hold_reg;
    logic                      out_valid_reg;
    logic signed [DIFF_W-1:0]  out_lat_reg;
    logic signed [DIFF_W-1:0]  out_lon_reg;
    logic                      out_taken_reg;

    logic [2*DIFF_W-1:0]       ring_mem [WINDOW];
    logic [2*DIFF_W-1:0]       rd_data_reg;

    logic                      window_full;
    logic                      mem_we;
    logic                      div_start;
    logic                      lat_done;
    logic                      lon_done;
    logic                      load_out;
    logic signed [DIFF_W-1:0]  old_lat;
    logic signed [DIFF_W-1:0]  old_lon;
    logic signed [SUM_W-1:0]   lat_add;
    logic signed [SUM_W-1:0]   lon_add;
    logic signed [SUM_W-1:0]   lat_sub;
    logic signed [SUM_W-1:0]   lon_sub;
    logic signed [SUM_W-1:0]   lat_sum_next;
    logic signed [SUM_W-1:0]   lon_sum_next;
    logic signed [DIFF_W-1:0]  lat_quot;
    logic signed [DIFF_W-1:0]  lon_quot;

    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign mem_we    = state_reg == ST_UPDATE;
    assign div_start = state_reg == ST_LAUNCH;
    assign load_out  = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    // Once the window is full the oldest difference, read from the slot about to
    // be overwritten, leaves the sums.
    assign window_full = count_reg == CNT_W'(WINDOW);
    assign old_lat = window_full ? rd_data_reg[2*DIFF_W-1:DIFF_W] : '0;
    assign old_lon = window_full ? rd_data_reg[DIFF_W-1:0] : '0;
    assign lat_add = SUM_W'(item_reg.lat_diff);
    assign lon_add = SUM_W'(item_reg.lon_diff);
    assign lat_sub = SUM_W'(old_lat);
    assign lon_sub = SUM_W'(old_lon);
    assign lat_sum_next = lat_sum_reg + lat_add - lat_sub;
    assign lon_sum_next = lon_sum_reg + lon_add - lon_sub;

    // Ring of differences; read data is registered, valid in the cycle after the slot is presented.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[slot_reg] <= {item_reg.lat_diff, item_reg.lon_diff};
        end
        rd_data_reg <= ring_mem[slot_reg];
    end

    // Mean dividers, one per axis, run side by side.
    gpea_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_lat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lat_sum_reg),
        .divisor  (count_reg),
        .done     (lat_done),
        .quotient (lat_quot)
    );

    gpea_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_lon_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lon_sum_reg),
        .divisor  (count_reg),
        .done     (lon_done),
        .quotient (lon_quot)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.take ? ST_UPDATE : ST_RESULT;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (lat_done && lon_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and window bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            count_reg     <= '0;
            lat_sum_reg   <= '0;
            lon_sum_reg   <= '0;
            lat_hold_reg  <= '0;
            lon_hold_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
            begin
                lat_sum_reg <= lat_sum_next;
                lon_sum_reg <= lon_sum_next;
                slot_reg    <= (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + IDX_W'(1);
                if (!window_full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if ((state_reg == ST_DIVIDE) && lat_done && lon_done)
            begin
                lat_hold_reg <= lat_quot;
                lon_hold_reg <= lon_quot;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Current transaction and result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
        end
        if (load_out)
        begin
            out_lat_reg   <= lat_hold_reg;
            out_lon_reg   <= lon_hold_reg;
            out_taken_reg <= item_reg.take;
        end
    end

    assign out_valid            = out_valid_reg;
    assign mean_latitude_error  = out_lat_reg;
    assign mean_longitude_error = out_lon_reg;
    assign sample_taken         = out_taken_reg;

endmodule

[sv/gated_position_error_average_unit.sv]
// The back end takes one sample at a time from the queue and pops the next only after the
// last result is loaded; a taken sample waits on the bit-serial mean divider (one quotient
// bit per cycle over the 32 + log2(WINDOW) bit sum), while a sample rejected for roll skips
// the window update and the divider.
// Reset clears the window count, sums, held means and all handshake state and sets
// roll_limit to 1280; the difference ring is not cleared, as no slot's data is used before it is written.
module gated_position_error_average_unit #(
    parameter int WINDOW = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gpea_pkg::APB_AW-1:0]         paddr,
    input  logic [gpea_pkg::APB_DW-1:0]         pwdata,
    output logic [gpea_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gpea_pkg::ROLL_W-1:0]  roll_angle,
    input  logic signed [gpea_pkg::POS_W-1:0]   ins_latitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   ins_longitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   gps_latitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   gps_longitude,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gpea_pkg::DIFF_W-1:0]  mean_latitude_error,
    output logic signed [gpea_pkg::DIFF_W-1:0]  mean_longitude_error,
    output logic                                sample_taken
);

    logic [gpea_pkg::LIMIT_W-1:0] roll_limit_reg;
    logic                         cfg_write;
    logic                         sel_roll_limit;
    logic                         q_full;
    logic                         q_valid;
    logic                         push;
    logic                         pop;
    gpea_pkg::item_t              push_item;
    gpea_pkg::item_t              q_item;

    // Configuration register; the register index is carried in paddr[2].
    assign pready         = 1'b1;
    assign sel_roll_limit = paddr[2] == gpea_pkg::REG_ROLL_LIMIT;
    assign cfg_write      = psel && penable && pwrite && pready;
    assign prdata         = sel_roll_limit ? gpea_pkg::APB_DW'(roll_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_limit_reg <= gpea_pkg::ROLL_LIMIT_RESET;
        end
        else if (cfg_write && sel_roll_limit)
        begin
            roll_limit_reg <= pwdata[gpea_pkg::LIMIT_W-1:0];
        end
    end

    // Front end: accept and classify.
    gpea_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .roll_angle    (roll_angle),
        .ins_latitude  (ins_latitude),
        .ins_longitude (ins_longitude),
        .gps_latitude  (gps_latitude),
        .gps_longitude (gps_longitude),
        .roll_limit    (roll_limit_reg),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Queue between front and back.
    gpea_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_item    (q_item)
    );

    // Back end: window, sums, division and result register.
    gpea_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_valid              (q_valid),
        .q_item               (q_item),
        .pop                  (pop),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .mean_latitude_error  (mean_latitude_error),
        .mean_longitude_error (mean_longitude_error),
        .sample_taken         (sample_taken)
    );

endmodule

[sv/gpea_checker.sv]
// Port-level checker for the gated position error average unit, with its bind.
`include "gated_position_error_average_unit_macros.svh"

module gpea_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gpea_pkg::APB_AW-1:0]         paddr,
    input  logic [gpea_pkg::APB_DW-1:0]         pwdata,
    input  logic [gpea_pkg::APB_DW-1:0]         prdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [gpea_pkg::ROLL_W-1:0]  roll_angle,
    input  logic signed [gpea_pkg::POS_W-1:0]   ins_latitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   ins_longitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   gps_latitude,
    input  logic signed [gpea_pkg::POS_W-1:0]   gps_longitude,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [gpea_pkg::DIFF_W-1:0]  mean_latitude_error,
    input  logic signed [gpea_pkg::DIFF_W-1:0]  mean_longitude_error,
    input  logic                                sample_taken
);

    // A stalled result transaction stays offered with the same contents.
    `GPEA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mean_latitude_error) && $stable(mean_longitude_error) && $stable(sample_taken), "result changed while stalled")

    // A written roll limit reads back on the following cycle.
    `GPEA_ASSERT_NXT(a_limit_readback, psel && penable && pwrite && pready && (paddr[2] == gpea_pkg::REG_ROLL_LIMIT), (paddr[2] != gpea_pkg::REG_ROLL_LIMIT) || (prdata[gpea_pkg::LIMIT_W-1:0] == $past(pwdata[gpea_pkg::LIMIT_W-1:0])), "roll limit readback mismatch")

    // The limit register is 16 bits; the upper read data stays zero.
    `GPEA_ASSERT_IMP(a_prdata_upper, 1'b1, prdata[gpea_pkg::APB_DW-1:gpea_pkg::LIMIT_W] == '0, "upper read data not zero")

    // No result is offered right out of reset.
    `GPEA_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid, "result offered out of reset")

endmodule

bind gated_position_error_average_unit gpea_checker u_gpea_checker (.*);
